>>> hw/rtl/month_calendar_grid_generator_defines.svh
// ----------------------------------------------------------------------------
// Month calendar grid generator: assertion macros
// Shared assertion forms for the port checker. Each macro expands to one
// labeled concurrent assertion clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MONTH_CALENDAR_GRID_GENERATOR_DEFINES_SVH
`define MONTH_CALENDAR_GRID_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCGG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCGG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mcgg_pkg.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator package
// Types, constants and month tables shared by the controller and datapath.
// ----------------------------------------------------------------------------
package mcgg_pkg;

   localparam int unsigned YearWidth  = 14;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned DayWidth   = 5;

   localparam logic [YearWidth-1:0]  FirstYear  = 14'd1582;
   localparam logic [YearWidth-1:0]  LastYear   = 14'd9999;
   localparam logic [MonthWidth-1:0] FirstMonth = 4'd1;
   localparam logic [MonthWidth-1:0] LastMonth  = 4'd12;
   localparam logic [MonthWidth-1:0] February   = 4'd2;

   // Leap days counted up to the end of 1581: 395 - 15 + 3.
   localparam int unsigned LeapsBeforeFirst = 383;
   localparam int unsigned FirstWeekday     = 5;
   // Constant part of the weekday sum: first year plus prior leaps, less the
   // weekday of 1 January 1582.
   localparam logic [14:0] DayBias = 15'(1582 + LeapsBeforeFirst - FirstWeekday);

   // floor(x / 100) = (x * 5243) >> 19 for every x below 43699.
   localparam logic [12:0] Recip100 = 13'd5243;
   localparam int unsigned Shift100 = 19;
   // floor(x / 7) = (x * 18725) >> 17 for every x below 43690.
   localparam logic [14:0] Recip7 = 15'd18725;
   localparam int unsigned Shift7 = 17;

   localparam logic [5:0] GridShort  = 6'd28;
   localparam logic [5:0] GridMiddle = 6'd35;
   localparam logic [5:0] GridLong   = 6'd42;
   localparam logic [2:0] WeekLength = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV100,
      ST_SUM,
      ST_DIV7,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;    // capture and clamp the request
      logic div100;  // century quotients
      logic sum;     // weekday sum and month length
      logic div7;    // quotient by seven
      logic setup;   // first weekday, grid size, cell counter start
      logic step;    // advance to the next cell
   } cmd_type;

   typedef struct packed {
      logic last_cell;
   } status_type;

   // Days in the months before the given one, for a common year.
   function automatic logic [8:0] days_before(input logic [MonthWidth-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Length of the given month in a common year.
   function automatic logic [DayWidth-1:0] month_length(input logic [MonthWidth-1:0] m);
      logic [DayWidth-1:0] d;
      case (m)
         4'd2:                  d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:               d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

>>> hw/rtl/mcgg_ctrl.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator controller
// Sequences the weekday calculation steps and the cell emission.
// ----------------------------------------------------------------------------
module mcgg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mcgg_pkg::status_type status,
   output mcgg_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                strobe
);
   import mcgg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DIV100;
         end
         ST_DIV100: state_in = ST_SUM;
         ST_SUM:    state_in = ST_DIV7;
         ST_DIV7:   state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.last_cell) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      busy   = 1'b1;
      strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIV100: cmd.div100 = 1'b1;
         ST_SUM:    cmd.sum    = 1'b1;
         ST_DIV7:   cmd.div7   = 1'b1;
         ST_SETUP:  cmd.setup  = 1'b1;
         ST_EMIT: begin
            cmd.step = 1'b1;
            strobe   = 1'b1;
         end
         default:   busy = 1'b1;
      endcase
   end

endmodule

>>> hw/rtl/mcgg_dp.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator datapath
// Clamps the request, finds the first weekday and walks the grid cells.
// ----------------------------------------------------------------------------
module mcgg_dp (
   input  logic                                  clock,
   input  mcgg_pkg::cmd_type                     cmd,
   input  logic [mcgg_pkg::YearWidth-1:0]        year,
   input  logic [mcgg_pkg::MonthWidth-1:0]       month,
   output mcgg_pkg::status_type                  status,
   output logic [mcgg_pkg::DayWidth-1:0]         day_number,
   output logic                                  end_of_week,
   output logic                                  last
);
   import mcgg_pkg::*;

   logic [YearWidth-1:0]  year_ff, year_in;
   logic [MonthWidth-1:0] month_ff, month_in;
   logic [YearWidth-1:0]  prev_year;
   logic [26:0]           prod_prev_ff, prod_year_ff;
   logic [6:0]            cent_prev, cent_year;
   logic [YearWidth-1:0]  rem100;
   logic                  leap;
   logic [14:0]           total_ff, total_in;
   logic [DayWidth-1:0]   mlen_ff, mlen_in;
   logic [29:0]           prod7_ff;
   logic [12:0]           quot7;
   logic [14:0]           rem7;
   logic [2:0]            start_ff;
   logic [5:0]            used_ff, used_in;
   logic [5:0]            count_ff, count_in;
   logic [5:0]            idx_ff;
   logic [2:0]            wk_ff;
   logic [5:0]            offset;

   // Clamp year and month into range.
   always_comb begin
      year_in = year;
      if (year < FirstYear) year_in = FirstYear;
      if (year > LastYear)  year_in = LastYear;
      month_in = month;
      if (month < FirstMonth) month_in = FirstMonth;
      if (month > LastMonth)  month_in = LastMonth;
   end

   assign prev_year = year_ff - 14'd1;
   assign cent_prev = prod_prev_ff[Shift100+6:Shift100];
   assign cent_year = prod_year_ff[Shift100+6:Shift100];

   // Leap rule: divisible by 4, and not a century unless divisible by 400.
   assign rem100 = year_ff - {1'b0, cent_year, 6'b0} - {2'b0, cent_year, 5'b0}
                   - {5'b0, cent_year, 2'b0};
   assign leap   = (year_ff[1:0] == 2'b00) &&
                   ((rem100 != '0) || (cent_year[1:0] == 2'b00));

   // Everything below is taken modulo 7 later; 365 is 1 modulo 7, so one day
   // per elapsed year stands in for a whole year.
   always_comb begin
      total_in = 15'(year_ff) + 15'(prev_year[YearWidth-1:2]) + 15'(cent_prev[6:2])
               + 15'(days_before(month_ff))
               + 15'(leap && (month_ff > February))
               - 15'(cent_prev) - DayBias;
      mlen_in  = month_length(month_ff) + DayWidth'(leap && (month_ff == February));
   end

   assign quot7 = prod7_ff[Shift7+12:Shift7];
   assign rem7  = total_ff - {quot7[11:0], 3'b0} + {2'b0, quot7};

   always_comb begin
      used_in = 6'(rem7[2:0]) + 6'(mlen_ff);
      if (used_in <= GridShort) begin
         count_in = GridShort;
      end else if (used_in <= GridMiddle) begin
         count_in = GridMiddle;
      end else begin
         count_in = GridLong;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff  <= year_in;
         month_ff <= month_in;
      end
      if (cmd.div100) begin
         prod_prev_ff <= 27'(prev_year) * 27'(Recip100);
         prod_year_ff <= 27'(year_ff) * 27'(Recip100);
      end
      if (cmd.sum) begin
         total_ff <= total_in;
         mlen_ff  <= mlen_in;
      end
      if (cmd.div7) begin
         prod7_ff <= 30'(total_ff) * 30'(Recip7);
      end
      if (cmd.setup) begin
         start_ff <= rem7[2:0];
         used_ff  <= used_in;
         count_ff <= count_in;
         idx_ff   <= 6'd1;
         wk_ff    <= 3'd1;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 6'd1;
         wk_ff  <= (wk_ff == WeekLength) ? 3'd1 : wk_ff + 3'd1;
      end
   end

   assign offset           = idx_ff - 6'(start_ff);
   assign day_number       = ((idx_ff > 6'(start_ff)) && (idx_ff <= used_ff)) ?
                             offset[DayWidth-1:0] : '0;
   assign end_of_week      = (wk_ff == WeekLength);
   assign last             = (idx_ff == count_ff);
   assign status.last_cell = last;

endmodule

>>> hw/rtl/month_calendar_grid_generator.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator
// Emits the Sunday-first day grid of one Gregorian month, one cell a cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block clamps the
// year to 1582..9999 and the month to 1..12, then finds the weekday of the
// first of the month in steps: constant-reciprocal multiplies for the century
// counts, the day sum, the reciprocal multiply by seven and forming the grid
// size. It then emits the grid on consecutive cycles, one cell per cycle with
// rsp_strobe high, 28, 35 or 42 cells.
// Busy stays high from the cycle after acceptance until the cycle after the
// cell flagged rsp_last. The receiver cannot stall: every cell is valid for
// exactly one cycle and must be taken then. Blank cells carry day number zero,
// and rsp_end_of_week marks the seventh cell of each row.
module month_calendar_grid_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mcgg_pkg::YearWidth-1:0]        req_year,
   input  logic [mcgg_pkg::MonthWidth-1:0]       req_month,
   output logic                                  rsp_strobe,
   output logic [mcgg_pkg::DayWidth-1:0]         rsp_day_number,
   output logic                                  rsp_end_of_week,
   output logic                                  rsp_last
);
   import mcgg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences the steps; it accepts a request only when idle.
   mcgg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   // The datapath holds the clamped request, the weekday arithmetic and the
   // cell counter that drives the result ports.
   mcgg_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .year        (req_year),
      .month       (req_month),
      .status      (status),
      .day_number  (rsp_day_number),
      .end_of_week (rsp_end_of_week),
      .last        (rsp_last)
   );

endmodule

>>> hw/rtl/mcgg_checker.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator port checker
// Watches the top-level ports for grid framing and handshake consistency.
// ----------------------------------------------------------------------------
`include "month_calendar_grid_generator_defines.svh"

module mcgg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_strobe,
   input logic                                  rsp_end_of_week,
   input logic                                  rsp_last
);

   `MCGG_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy, "cell shown while idle")
   `MCGG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request not taken")
   `MCGG_ASSERT_SAME(a_last_eow, rsp_strobe && rsp_last, rsp_end_of_week, "grid ends mid-week")
   `MCGG_ASSERT_NEXT(a_last_stops, rsp_strobe && rsp_last, !rsp_strobe, "cell after last")
   `MCGG_ASSERT_NEXT(a_cells_run, rsp_strobe && !rsp_last, rsp_strobe, "gap inside a grid")

endmodule

bind month_calendar_grid_generator mcgg_checker u_mcgg_checker (.*);

>>> bench/month_calendar_grid_generator_checker.sv
// ----------------------------------------------------------------------------
// Month calendar grid checker
// Watches the request and cell ports, predicts each month grid and compares
// every emitted cell with the oldest predicted cell.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [mcgg_pkg::YearWidth-1:0]  req_year,
   input  logic [mcgg_pkg::MonthWidth-1:0] req_month,
   input  logic                            rsp_strobe,
   input  logic [mcgg_pkg::DayWidth-1:0]   rsp_day_number,
   input  logic                            rsp_end_of_week,
   input  logic                            rsp_last,
   output int                              error_count,
   output int                              cells_outstanding
);
   import mcgg_pkg::*;

   localparam int DaysPerWeek = 7;

   typedef struct packed {
      logic [DayWidth-1:0] day;
      logic                week_end;
      logic                grid_end;
   } grid_cell_type;

   grid_cell_type predicted_cells[$];
   int            mismatches = 0;
   int            outstanding = 0;

   assign error_count       = mismatches;
   assign cells_outstanding = outstanding;

   function automatic int days_in_month(input int m, input bit leap);
      int n;
      case (m)
         2:           n = leap ? 29 : 28;
         4, 6, 9, 11: n = 30;
         default:     n = 31;
      endcase
      return n;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Queues every cell of the grid that one request should produce.
   task automatic predict_month_grid(input logic [YearWidth-1:0] year_in,
                                     input logic [MonthWidth-1:0] month_in);
      int            y;
      int            m;
      int            k;
      int            p;
      int            days;
      int            first_wd;
      int            mlen;
      int            used;
      int            total;
      int            d;
      bit            leap;
      grid_cell_type c;
      y = int'(year_in);
      m = int'(month_in);
      if (y < int'(FirstYear)) y = int'(FirstYear);
      if (y > int'(LastYear)) y = int'(LastYear);
      if (m < int'(FirstMonth)) m = int'(FirstMonth);
      if (m > int'(LastMonth)) m = int'(LastMonth);
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      days = (y - int'(FirstYear)) * 365;
      if (y > int'(FirstYear)) begin
         p = y - 1;
         days = days + p / 4 - p / 100 + p / 400 - int'(LeapsBeforeFirst);
      end
      // Earlier months already include the leap day when February is past.
      for (k = 1; k < m; k++) days = days + days_in_month(k, leap);
      mlen     = days_in_month(m, leap);
      first_wd = (days % DaysPerWeek + int'(FirstWeekday)) % DaysPerWeek;
      used     = first_wd + mlen;
      total    = ((used + DaysPerWeek - 1) / DaysPerWeek) * DaysPerWeek;
      for (k = 1; k <= total; k++) begin
         d = (k > first_wd && k <= used) ? k - first_wd : 0;
         c.day      = DayWidth'(d);
         c.week_end = (k % DaysPerWeek == 0);
         c.grid_end = (k == total);
         predicted_cells.push_back(c);
      end
   endtask

   always @(posedge clock) begin : watch
      grid_cell_type want;
      if (reset === 1'b0) begin
         if (start === 1'b1 && busy === 1'b0) predict_month_grid(req_year, req_month);
         if (rsp_strobe === 1'b1) begin
            if (predicted_cells.size() == 0) begin
               report_mismatch("cell with no request outstanding", rsp_day_number, -1);
            end else begin
               want = predicted_cells.pop_front();
               if (rsp_day_number !== want.day)
                  report_mismatch("day number", rsp_day_number, want.day);
               if (rsp_end_of_week !== want.week_end)
                  report_mismatch("end of week", rsp_end_of_week, want.week_end);
               if (rsp_last !== want.grid_end)
                  report_mismatch("last", rsp_last, want.grid_end);
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("strobe unknown", 0, 0);
         end
      end
      outstanding = predicted_cells.size();
   end

endmodule

>>> bench/month_calendar_grid_generator_tb.sv
// ----------------------------------------------------------------------------
// Month calendar grid generator testbench
// Sends directed and random year/month requests to the block and lets the
// checker compare every emitted grid cell against its own prediction.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator_tb;
   import mcgg_pkg::*;

   // Even with the longest grids, a few hundred requests with
   // sender gaps finish well inside this bound.
   localparam int CycleLimit     = 200000;
   localparam int RandomRequests = 258;
   localparam int DrainCycles    = 60;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [YearWidth-1:0]  req_year = '0;
   logic [MonthWidth-1:0] req_month = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [DayWidth-1:0]   rsp_day_number;
   logic                  rsp_end_of_week;
   logic                  rsp_last;

   int error_count;
   int cells_outstanding;
   int cycle_count = 0;

   // Chance, in percent, that the sender drops start for a gap after each
   // accepted request; the draw repeats after each gap.
   int sender_gap_pct = 27;

   month_calendar_grid_generator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_year        (req_year),
      .req_month       (req_month),
      .rsp_strobe      (rsp_strobe),
      .rsp_day_number  (rsp_day_number),
      .rsp_end_of_week (rsp_end_of_week),
      .rsp_last        (rsp_last)
   );

   month_calendar_grid_generator_checker grid_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_year          (req_year),
      .req_month         (req_month),
      .rsp_strobe        (rsp_strobe),
      .rsp_day_number    (rsp_day_number),
      .rsp_end_of_week   (rsp_end_of_week),
      .rsp_last          (rsp_last),
      .error_count       (error_count),
      .cells_outstanding (cells_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hung block or a lost handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Presents one request and holds it until the block takes it. The busy
   // value read right after the edge is the one the block saw at that edge,
   // so the loop leaves on exactly the accepting edge. Start stays high
   // unless a gap is drawn; the block raises busy on acceptance, so the
   // same request is never taken twice.
   task automatic send_request(input logic [YearWidth-1:0] y,
                               input logic [MonthWidth-1:0] m);
      start     <= 1'b1;
      req_year  <= y;
      req_month <= m;
      do @(posedge clock); while (busy !== 1'b0);
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Most random requests use in-range years, with a share of years below,
   // above and right at the clamp limits, century years that test the leap
   // rule, and raw 14-bit values so that every bit toggles.
   task automatic pick_request(output logic [YearWidth-1:0] y,
                               output logic [MonthWidth-1:0] m);
      case ($urandom_range(9))
         0:       y = YearWidth'($urandom_range(16383));
         1:       y = YearWidth'($urandom_range(1581));
         2:       y = YearWidth'($urandom_range(16383, 10000));
         3:       y = YearWidth'(1582 + $urandom_range(20));
         4:       y = YearWidth'(9999 - $urandom_range(20));
         5:       y = YearWidth'(100 * $urandom_range(99, 16));
         default: y = YearWidth'($urandom_range(9999, 1582));
      endcase
      if ($urandom_range(99) < 85) m = MonthWidth'($urandom_range(12, 1));
      else m = MonthWidth'($urandom_range(15));
   endtask

   initial begin : stimulus
      logic [YearWidth-1:0]  y;
      logic [MonthWidth-1:0] m;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Clamping of the year: zero, just below, at both limits, just above,
      // and all ones.
      send_request(14'd0, 4'd1);
      send_request(14'd1581, 4'd6);
      send_request(14'd1582, 4'd1);
      send_request(14'd1582, 4'd10);
      send_request(14'd1583, 4'd1);
      send_request(14'd9999, 4'd12);
      send_request(14'd10000, 4'd7);
      send_request(14'd16383, 4'd15);
      // Clamping of the month: zero and every value above December.
      send_request(14'd2024, 4'd0);
      send_request(14'd2024, 4'd13);
      send_request(14'd2024, 4'd14);
      send_request(14'd2024, 4'd15);
      // Leap rule: a leap century, common centuries, an ordinary leap year
      // and a common year, on February and on the month after it.
      send_request(14'd1600, 4'd2);
      send_request(14'd1700, 4'd2);
      send_request(14'd1900, 4'd3);
      send_request(14'd2000, 4'd2);
      send_request(14'd2000, 4'd3);
      send_request(14'd2024, 4'd2);
      send_request(14'd2023, 4'd2);
      // A February starting on Sunday fills exactly four rows, and a 31-day
      // month starting on Friday needs all six.
      send_request(14'd2015, 4'd2);
      send_request(14'd2016, 4'd1);
      // A year with its low thirteen bits set and a year with a single bit set.
      send_request(14'd8191, 4'd5);
      send_request(14'd4096, 4'd8);

      // Random requests in three phases: light sender gaps, heavy gaps, and
      // back-to-back requests with start held high throughout.
      for (int phase = 0; phase < 3; phase++) begin
         sender_gap_pct = (phase == 0) ? 27 : (phase == 1) ? 52 : 0;
         for (int n = 0; n < RandomRequests / 3; n++) begin
            pick_request(y, m);
            send_request(y, m);
         end
      end
      start <= 1'b0;

      // Let every predicted cell arrive, then watch a while longer for any
      // cell the block should not have produced.
      while (cells_outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0 && cells_outstanding == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mcgg_pkg.sv
hw/rtl/mcgg_ctrl.sv
hw/rtl/mcgg_dp.sv
hw/rtl/month_calendar_grid_generator.sv
hw/rtl/mcgg_checker.sv
bench/month_calendar_grid_generator_checker.sv
bench/month_calendar_grid_generator_tb.sv
